>>> rtl/core/text_console_writer_macros.svh
// assertion macros of the text console writer, used by tcw_ctrl
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TCW_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("text console writer assertion failed");

// next-cycle implication, checked out of reset
`define TCW_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("text console writer assertion failed");

`endif

>>> rtl/core/tcw_pkg.sv
// types and constants of the text console writer
package tcw_pkg;

	localparam int COLUMNS  = 80;
	localparam int LAST_ROW = 24;
	localparam int TAB_STEP = 4;
	localparam int ROWS     = LAST_ROW + 1;
	localparam int CELLS    = ROWS * COLUMNS;
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int ROW_W    = 5;
	localparam int COL_W    = 7;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_BLANK   = 8'h20;
	localparam logic [7:0] CHAR_LAST    = 8'h7f;
	localparam logic [7:0] RESET_ATTR   = 8'h0e;

	localparam logic CMD_PUT  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [7:0]       char_code;
		logic [ROW_W-1:0] read_row;
		logic [COL_W-1:0] read_col;
	} req_t;

	typedef struct packed {
		logic [ROW_W-1:0] cursor_row_out;
		logic [COL_W-1:0] cursor_col_out;
		logic [7:0]       cell_char;
		logic [7:0]       cell_attr;
	} rsp_t;

	typedef struct packed {
		logic [7:0] attr;
		logic [7:0] code;
	} cell_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		cell_t             wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

>>> rtl/core/tcw_cell_ram.sv
// screen cell store, one write and one registered read port
module tcw_cell_ram import tcw_pkg::*; (
	input  logic     clk,
	input  mem_req_t mem,
	output cell_t    rdata
);

	cell_t cells [CELLS];
	cell_t rdata_q;

	always_ff @(posedge clk) begin
		if (mem.we) begin
			cells[mem.waddr] <= mem.wdata;
		end
		if (mem.re) begin
			rdata_q <= cells[mem.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/tcw_ctrl.sv
// cursor, scroll and clear sequencer of the text console writer
`include "text_console_writer_macros.svh"

module tcw_ctrl import tcw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       attr_we,
	input  logic [7:0] attr_wdata,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp,
	output mem_req_t   mem,
	input  cell_t      rdata
);

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_SCRL = 2'd3;

	logic [1:0]        state_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [COL_W-1:0]  clr_col_q;
	logic [ROW_W-1:0]  clr_row_q;
	logic [ROW_W-1:0]  top_q;
	logic [ROW_W-1:0]  cursor_row_q;
	logic [COL_W-1:0]  cursor_col_q;
	logic [7:0]        attr_q;
	logic              is_read_s1;
	logic              in_range_s1;
	logic              scroll_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              accept;
	logic              rsp_free;
	logic              rd_in_range;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] cur_addr;
	logic              is_print;
	logic [COL_W:0]    col_inc;
	logic [COL_W:0]    col_tab;
	logic [ROW_W:0]    row_nxt;
	logic [COL_W-1:0]  col_nxt;
	logic              scroll_nxt;

	function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_W:0] sum);
		if (sum >= (ROW_W+1)'(ROWS)) begin
			return ROW_W'(sum - (ROW_W+1)'(ROWS));
		end
		return ROW_W'(sum);
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
			input logic [COL_W-1:0] col);
		return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

	assign accept    = (state_q == ST_IDLE) && req_valid;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign rd_in_range = (req.read_row <= ROW_W'(LAST_ROW)) && (req.read_col < COL_W'(COLUMNS));
	assign rd_addr     = cell_addr(wrap_row({1'b0, req.read_row} + {1'b0, top_q}), req.read_col);
	assign cur_addr    = cell_addr(wrap_row({1'b0, cursor_row_q} + {1'b0, top_q}), cursor_col_q);
	assign is_print    = (req.char_code >= CHAR_BLANK) && (req.char_code <= CHAR_LAST);

	// next cursor for a put item
	always_comb begin
		col_inc = {1'b0, cursor_col_q} + (COL_W+1)'(1);
		col_tab = {1'b0, cursor_col_q} + (COL_W+1)'(TAB_STEP);
		row_nxt = {1'b0, cursor_row_q};
		col_nxt = cursor_col_q;
		priority if (req.char_code == CHAR_NEWLINE) begin
			col_nxt = '0;
			row_nxt = {1'b0, cursor_row_q} + (ROW_W+1)'(1);
		end else if (req.char_code == CHAR_TAB) begin
			if (col_tab >= (COL_W+1)'(COLUMNS)) begin
				col_nxt = COL_W'(col_tab - (COL_W+1)'(COLUMNS));
				row_nxt = {1'b0, cursor_row_q} + (ROW_W+1)'(1);
			end else begin
				col_nxt = COL_W'(col_tab);
			end
		end else if (is_print) begin
			if (col_inc >= (COL_W+1)'(COLUMNS)) begin
				col_nxt = '0;
				row_nxt = {1'b0, cursor_row_q} + (ROW_W+1)'(1);
			end else begin
				col_nxt = COL_W'(col_inc);
			end
		end else begin
			col_nxt = cursor_col_q;
		end
		scroll_nxt = row_nxt > (ROW_W+1)'(LAST_ROW);
	end

	// memory port
	always_comb begin
		mem = '0;
		unique case (state_q)
			ST_CLR: begin
				mem.we    = 1'b1;
				mem.waddr = clr_addr_q;
				mem.wdata = '{attr: RESET_ATTR, code: CHAR_BLANK};
			end
			ST_IDLE: begin
				if (accept && req.cmd == CMD_READ) begin
					mem.re    = rd_in_range;
					mem.raddr = rd_addr;
				end else if (accept && is_print) begin
					mem.we    = 1'b1;
					mem.waddr = cur_addr;
					mem.wdata = '{attr: attr_q, code: req.char_code};
				end
			end
			ST_SCRL: begin
				mem.we    = 1'b1;
				mem.waddr = cell_addr(clr_row_q, clr_col_q);
				mem.wdata = '{attr: attr_q, code: CHAR_BLANK};
			end
			default: begin
				mem = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_addr_q   <= '0;
			clr_col_q    <= '0;
			top_q        <= '0;
			cursor_row_q <= '0;
			cursor_col_q <= '0;
			attr_q       <= RESET_ATTR;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (attr_we) begin
				attr_q <= attr_wdata;
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_FIN;
						if (req.cmd == CMD_PUT) begin
							cursor_col_q <= col_nxt;
							cursor_row_q <= scroll_nxt ? ROW_W'(LAST_ROW) : ROW_W'(row_nxt);
						end
					end
				end
				ST_FIN: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						if (scroll_s1) begin
							state_q <= ST_SCRL;
							top_q   <= (top_q == ROW_W'(LAST_ROW)) ? '0 : top_q + ROW_W'(1);
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SCRL: begin
					if (clr_col_q == COL_W'(COLUMNS - 1)) begin
						clr_col_q <= '0;
						state_q   <= ST_IDLE;
					end else begin
						clr_col_q <= clr_col_q + COL_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_read_s1  <= (req.cmd == CMD_READ);
			in_range_s1 <= rd_in_range;
			scroll_s1   <= (req.cmd == CMD_PUT) && scroll_nxt;
		end
		if (state_q == ST_FIN && rsp_free) begin
			// old top row becomes the new bottom row
			clr_row_q            <= top_q;
			rsp_q.cursor_row_out <= cursor_row_q;
			rsp_q.cursor_col_out <= cursor_col_q;
			if (is_read_s1 && in_range_s1) begin
				rsp_q.cell_char <= rdata.code;
				rsp_q.cell_attr <= rdata.attr;
			end else begin
				rsp_q.cell_char <= '0;
				rsp_q.cell_attr <= '0;
			end
		end
	end

	`TCW_ASSERT_NXT(a_accept_to_fin, accept, state_q == ST_FIN)
	`TCW_ASSERT_IMP(a_rsp_from_fin, $rose(rsp_valid_q), $past(state_q) == ST_FIN)
	`TCW_ASSERT_IMP(a_pos_in_range, 1'b1, cursor_row_q <= ROW_W'(LAST_ROW) && cursor_col_q < COL_W'(COLUMNS) && top_q <= ROW_W'(LAST_ROW))
	`TCW_ASSERT_IMP(a_waddr_in_range, mem.we, mem.waddr < ADDR_W'(CELLS) && !mem.re)

endmodule

>>> rtl/core/text_console_writer.sv
// text console writer: an accepted item moves to the FIN state, where its result is registered once the output is free
// a new item stalls while the last one waits in FIN (store read and result register step) or in its scroll clear
// a put that scrolls adds a clear of one row of 80 cells, one cell written per cycle
// after reset a clearing pass fills all 2000 cells of the store with blanks; items stall meanwhile
// the attribute register is written any time, it resets to 0x0e; cursor and scroll base reset to 0
module text_console_writer import tcw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       attr_we,
	input  logic [7:0] attr_wdata,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp
);

	mem_req_t mem;
	cell_t    rdata;

	tcw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.attr_we    (attr_we),
		.attr_wdata (attr_wdata),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.mem        (mem),
		.rdata      (rdata)
	);

	tcw_cell_ram u_ram (
		.clk   (clk),
		.mem   (mem),
		.rdata (rdata)
	);

endmodule
